>>> hw/rtl/rsmp_pkg.sv
package rsmp_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int WEIGHT_BITS   = 16;

   localparam int IDX_W   = $clog2(MAX_PARTICLES);
   localparam int CNT_W   = 11;
   localparam int SUM_W   = 27;
   localparam int PROD_W  = SUM_W + CNT_W;
   localparam int REACH_W = PROD_W - WEIGHT_BITS + 1;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);
   localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [WEIGHT_BITS-1:0] start_offset;
      logic                   first;
      logic                   last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] particle_index;
      logic [CNT_W-1:0] copy_count;
      logic             shortfall;
      logic             last_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/rsmp_front.sv
module rsmp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rsmp_pkg::req_type req_data,
   output logic              q_valid,
   output rsmp_pkg::req_type q_data,
   input  logic              q_pop
);

   rsmp_pkg::req_type                  mem_ff [rsmp_pkg::QUEUE_DEPTH];
   logic [rsmp_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rsmp_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rsmp_pkg::QUEUE_AW:0]        fill_ff, fill_in;
   logic                               push;
   logic                               pop;

   assign req_stall = (fill_ff == (rsmp_pkg::QUEUE_AW+1)'(rsmp_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rsmp_pkg::QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + rsmp_pkg::QUEUE_AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (rsmp_pkg::QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (rsmp_pkg::QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

>>> hw/rtl/rsmp_back.sv
module rsmp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rsmp_pkg::CNT_W-1:0]     draw_total,
   input  logic                           q_valid,
   input  rsmp_pkg::req_type              q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rsmp_pkg::rsp_type              rsp_data
);

   rsmp_pkg::state_type                    state_ff, state_in;

   logic [rsmp_pkg::SUM_W-1:0]             sum_ff, sum_in;
   logic [rsmp_pkg::CNT_W-1:0]             draw_ff, draw_in;
   logic [rsmp_pkg::IDX_W-1:0]             pos_ff, pos_in;
   logic [rsmp_pkg::WEIGHT_BITS-1:0]       offset_ff, offset_in;
   logic [rsmp_pkg::IDX_W-1:0]             cur_pos_ff, cur_pos_in;
   logic                                   cur_last_ff;
   logic [rsmp_pkg::PROD_W-1:0]            prod_ff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   rsmp_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   logic                                   out_free;
   logic                                   load;
   logic                                   out_write;
   logic [rsmp_pkg::SUM_W:0]               sum_wide;
   logic [rsmp_pkg::SUM_W-1:0]             sum_base;
   logic [rsmp_pkg::IDX_W:0]               pos_next;
   logic [rsmp_pkg::PROD_W-1:0]            diff;
   logic [rsmp_pkg::REACH_W-1:0]           reach;
   logic [rsmp_pkg::CNT_W-1:0]             served;
   logic [rsmp_pkg::CNT_W-1:0]             draw_upd;
   logic [rsmp_pkg::CNT_W-1:0]             count;
   logic                                   shortfall;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsmp_pkg::ST_IDLE: begin
            if (q_valid) state_in = rsmp_pkg::ST_MUL;
         end
         rsmp_pkg::ST_MUL: begin
            state_in = rsmp_pkg::ST_DONE;
         end
         rsmp_pkg::ST_DONE: begin
            if (out_free) state_in = q_valid ? rsmp_pkg::ST_MUL : rsmp_pkg::ST_IDLE;
         end
         default: begin
            state_in = rsmp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      load      = 1'b0;
      out_write = 1'b0;
      case (state_ff)
         rsmp_pkg::ST_IDLE: begin
            load = q_valid;
         end
         rsmp_pkg::ST_MUL: begin
            load = 1'b0;
         end
         rsmp_pkg::ST_DONE: begin
            out_write = out_free;
            load      = out_free && q_valid;
         end
         default: begin
            load      = 1'b0;
            out_write = 1'b0;
         end
      endcase
   end

   assign q_pop = load;

   // load: restart the pass on first, then saturate the weight sum
   always_comb begin
      sum_base  = q_data.first ? '0 : sum_ff;
      sum_wide  = {1'b0, sum_base} + (rsmp_pkg::SUM_W+1)'(q_data.weight);
      cur_pos_in = q_data.first ? '0 : pos_ff;
      pos_next  = {1'b0, cur_pos_in} + (rsmp_pkg::IDX_W+1)'(1);
      sum_in    = sum_ff;
      offset_in = offset_ff;
      pos_in    = pos_ff;
      if (load) begin
         sum_in    = sum_wide[rsmp_pkg::SUM_W] ? rsmp_pkg::SUM_MAX
                                               : sum_wide[rsmp_pkg::SUM_W-1:0];
         offset_in = q_data.first ? q_data.start_offset : offset_ff;
         pos_in    = (pos_next >= (rsmp_pkg::IDX_W+1)'(rsmp_pkg::MAX_PARTICLES))
                     ? '0 : pos_next[rsmp_pkg::IDX_W-1:0];
      end
   end

   // finish: count thresholds at or below sum*n, capped at n
   always_comb begin
      diff  = prod_ff - rsmp_pkg::PROD_W'(offset_ff);
      reach = (prod_ff >= rsmp_pkg::PROD_W'(offset_ff))
              ? (rsmp_pkg::REACH_W'(diff[rsmp_pkg::PROD_W-1:rsmp_pkg::WEIGHT_BITS])
                 + rsmp_pkg::REACH_W'(1)) : '0;
      served = (reach < rsmp_pkg::REACH_W'(draw_total))
               ? reach[rsmp_pkg::CNT_W-1:0] : draw_total;
      if (served > draw_ff) begin
         count    = served - draw_ff;
         draw_upd = served;
      end else begin
         count    = '0;
         draw_upd = draw_ff;
      end
      shortfall = cur_last_ff && (draw_upd < draw_total);

      draw_in = draw_ff;
      if (out_write) draw_in = draw_upd;
      if (load && q_data.first) draw_in = '0;

      rsp_data_in.particle_index = cur_pos_ff;
      rsp_data_in.copy_count     = count;
      rsp_data_in.shortfall      = shortfall;
      rsp_data_in.last_out       = cur_last_ff;

      rsp_valid_in = rsp_valid_ff;
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsmp_pkg::ST_IDLE;
         sum_ff       <= '0;
         draw_ff      <= '0;
         pos_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         draw_ff      <= draw_in;
         pos_ff       <= pos_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_pos_ff  <= cur_pos_in;
         cur_last_ff <= q_data.last;
      end
      if (state_ff == rsmp_pkg::ST_MUL) begin
         prod_ff <= rsmp_pkg::PROD_W'(sum_ff) * rsmp_pkg::PROD_W'(draw_total);
      end
      if (out_write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/systematic_resampler.sv
// Systematic resampler: one result per request, copy counts by cross-multiplied thresholds.
// Each request passes from the request queue through the load step, the multiply state and
// the compare-and-count (done) state into the registered result. The back unit finishes one
// request before it loads the next; a 2-entry request queue decouples input from compute.
// Reset (synchronous, active high) empties the queue and output register, zeroes the
// running sum, draw index, particle position and offset, and sets the draw count to 1024.
module systematic_resampler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  rsmp_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsmp_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_en,
   input  logic [rsmp_pkg::CNT_W-1:0] csr_write_data
);

   // number of draws per pass
   logic [rsmp_pkg::CNT_W-1:0] count_ff, count_in;

   logic              q_valid;
   logic              q_pop;
   rsmp_pkg::req_type q_data;

   // hold the register unless written
   assign count_in = csr_write_en ? csr_write_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= rsmp_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // front: accept requests and queue them
   rsmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   // back: advance running sum, multiply by draw count, then count served draws
   rsmp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .draw_total (count_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hw/rtl/rsmp_checker.sv
module rsmp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsmp_pkg::rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // shortfall only comes with the last particle
   a_short_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.shortfall |-> rsp_data.last_out)
      else $error("shortfall without last");

   // reset drops the result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // after reset no result appears before a request could pass through the block
   a_no_spurious: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result without request");

   // reset empties the request queue
   a_queue_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("request stalled after reset");

endmodule

bind systematic_resampler rsmp_checker u_rsmp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> bench/systematic_resampler_tb.sv
module systematic_resampler_tb;

   localparam int AWAIT_DEPTH = 64;

   // Clock, reset and block ports. Every input starts at a known value.
   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_stall;
   rsmp_pkg::req_type           req_data       = '0;
   logic                        rsp_valid;
   logic                        rsp_stall      = 1'b0;
   rsmp_pkg::rsp_type           rsp_data;
   logic                        csr_write_en   = 1'b0;
   logic [rsmp_pkg::CNT_W-1:0]  csr_write_data = '0;

   // Predicted copy-count results in a ring, oldest at the head.
   rsmp_pkg::rsp_type           awaited_draws[AWAIT_DEPTH];
   int unsigned                 await_head     = 0;
   int unsigned                 await_tail     = 0;
   int                          fail_count     = 0;

   // Shadow of the resampler state and its draw-count register.
   logic [rsmp_pkg::SUM_W-1:0]       sum_acc;
   logic [rsmp_pkg::CNT_W-1:0]       draw_next;
   logic [rsmp_pkg::IDX_W-1:0]       slot_pos;
   logic [rsmp_pkg::WEIGHT_BITS-1:0] offset_lat;
   logic [rsmp_pkg::CNT_W-1:0]       draw_total;

   // Idling controls shared by the sender, the receiver and the tests.
   bit                          req_idle_on    = 1'b1;
   bit                          rsp_idle_on    = 1'b1;
   int                          rsp_hold_cycles = 0;

   localparam int DRAIN_CYCLES = 6;
   localparam logic [rsmp_pkg::WEIGHT_BITS-1:0] W_MAX = {rsmp_pkg::WEIGHT_BITS{1'b1}};

   systematic_resampler dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none, often short, now and then long.
   function automatic int draw_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic rsmp_pkg::req_type make_req(
         input logic [rsmp_pkg::WEIGHT_BITS-1:0] w,
         input logic [rsmp_pkg::WEIGHT_BITS-1:0] off,
         input logic f, input logic l);
      rsmp_pkg::req_type r;
      r.weight       = w;
      r.start_offset = off;
      r.first        = f;
      r.last         = l;
      return r;
   endfunction

   // Advance the shadow state by one request and return the result it causes.
   // Thresholds are compared cross-multiplied: u + k*2^16 <= S*n.
   function automatic rsmp_pkg::rsp_type tally_draws(input rsmp_pkg::req_type r);
      logic [rsmp_pkg::SUM_W:0]     widened;
      logic [rsmp_pkg::PROD_W-1:0]  scaled;
      logic [rsmp_pkg::REACH_W-1:0] reach;
      logic [rsmp_pkg::REACH_W-1:0] served;
      rsmp_pkg::rsp_type            res;
      if (r.first) begin
         sum_acc    = '0;
         draw_next  = '0;
         slot_pos   = '0;
         offset_lat = r.start_offset;
      end
      // Saturate the running sum instead of wrapping.
      widened = (rsmp_pkg::SUM_W+1)'(sum_acc) + (rsmp_pkg::SUM_W+1)'(r.weight);
      sum_acc = (widened > (rsmp_pkg::SUM_W+1)'(rsmp_pkg::SUM_MAX))
                ? rsmp_pkg::SUM_MAX : widened[rsmp_pkg::SUM_W-1:0];
      scaled  = rsmp_pkg::PROD_W'(sum_acc) * rsmp_pkg::PROD_W'(draw_total);
      if (scaled >= rsmp_pkg::PROD_W'(offset_lat))
         reach = rsmp_pkg::REACH_W'((scaled - rsmp_pkg::PROD_W'(offset_lat))
                                    >> rsmp_pkg::WEIGHT_BITS) + rsmp_pkg::REACH_W'(1);
      else
         reach = '0;
      // Never draw past n.
      served = (reach < rsmp_pkg::REACH_W'(draw_total))
               ? reach : rsmp_pkg::REACH_W'(draw_total);
      res.copy_count = '0;
      if (served > rsmp_pkg::REACH_W'(draw_next)) begin
         res.copy_count = rsmp_pkg::CNT_W'(served - rsmp_pkg::REACH_W'(draw_next));
         draw_next      = rsmp_pkg::CNT_W'(served);
      end
      res.shortfall      = r.last && (draw_next < draw_total);
      res.particle_index = slot_pos;
      res.last_out       = r.last;
      // Position wraps at MAX_PARTICLES, which is the 10-bit range.
      slot_pos = slot_pos + rsmp_pkg::IDX_W'(1);
      return res;
   endfunction

   // Send one request. Enter just after a rising edge, leave at the edge that
   // accepts it. Valid stays high across back-to-back requests.
   task automatic send_request(input rsmp_pkg::req_type r);
      int gap;
      gap = draw_gap(req_idle_on);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      awaited_draws[await_tail % AWAIT_DEPTH] = tally_draws(r);
      await_tail++;
   endtask

   // Drop valid, then hold off until every predicted result has come back.
   task automatic wait_drained;
      @(negedge clock);
      req_valid = 1'b0;
      while (await_tail != await_head) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the draw count only while the block is empty.
   task automatic set_draw_count(input logic [rsmp_pkg::CNT_W-1:0] n);
      wait_drained();
      csr_write_en   = 1'b1;
      csr_write_data = n;
      @(negedge clock);
      csr_write_en   = 1'b0;
      draw_total     = n;
   endtask

   // Send a pass of m particles. Well-formed passes get weights summing to
   // 1.0 (a lone particle gets the largest weight); noisy ones get random
   // weights and random first/last marks.
   task automatic send_pass(input int m, input bit with_first, input bit with_last,
                            input bit noisy);
      int left, lo, hi, cap, w, pick;
      bit f, l;
      logic [rsmp_pkg::WEIGHT_BITS-1:0] off;
      left = 65536;
      for (int i = 0; i < m; i++) begin
         if (noisy) begin
            w = $urandom_range(0, 65535);
            f = ($urandom_range(0, 7) == 0);
            l = ($urandom_range(0, 7) == 0);
         end else begin
            lo = left - (m - i - 1) * 65535;
            if (lo < 0) lo = 0;
            hi = (left > 65535) ? 65535 : left;
            if (i == m - 1) begin
               w = hi;
            end else begin
               cap = 2 * left / (m - i);
               if (cap > hi) cap = hi;
               if (cap < lo) cap = lo;
               w = $urandom_range(0, 1) ? $urandom_range(lo, cap) : $urandom_range(lo, hi);
            end
            left -= w;
            f = with_first && (i == 0);
            l = with_last && (i == m - 1);
         end
         pick = $urandom_range(0, 15);
         if (pick == 0)      off = '0;
         else if (pick == 1) off = W_MAX;
         else                off = rsmp_pkg::WEIGHT_BITS'($urandom_range(0, 65535));
         send_request(make_req(rsmp_pkg::WEIGHT_BITS'(w), off, f, l));
      end
   endtask

   // Receiver: random stalls, plus long hold-offs requested by the tests,
   // counted down here cycle by cycle.
   initial begin : rsp_stall_drive
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left      = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = draw_gap(1'b1);
         end
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_check
      rsmp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (await_tail == await_head) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = awaited_draws[await_head % AWAIT_DEPTH];
            await_head++;
            check_field("particle_index", want.particle_index, rsp_data.particle_index);
            check_field("copy_count", want.copy_count, rsp_data.copy_count);
            check_field("shortfall", want.shortfall, rsp_data.shortfall);
            check_field("last_out", want.last_out, rsp_data.last_out);
         end
      end
   end

   // Before any first mark the reset state acts as a pass with offset 0; a
   // request after last without first keeps accumulating.
   task automatic test_before_first;
      send_request(make_req(W_MAX, W_MAX, 1'b0, 1'b0));
      send_request(make_req('0, '0, 1'b0, 1'b0));
      send_request(make_req(16'h0001, 16'h5A5A, 1'b0, 1'b1));
      send_request(make_req(16'h8000, 16'hA5A5, 1'b0, 1'b0));
   endtask

   // Field extremes at the reset draw count, including first and last together.
   task automatic test_field_extremes;
      send_request(make_req('0, W_MAX, 1'b1, 1'b0));
      send_request(make_req(W_MAX, '0, 1'b0, 1'b0));
      send_request(make_req(16'h0001, '0, 1'b0, 1'b1));
      send_request(make_req(W_MAX, '0, 1'b1, 1'b1));
      send_request(make_req(16'h8000, '0, 1'b1, 1'b0));
      send_request(make_req(16'h8000, W_MAX, 1'b0, 1'b1));
   endtask

   // Zero draws give no copies and no shortfall; one draw goes to one particle.
   task automatic test_draw_count_edges;
      set_draw_count('0);
      send_request(make_req(16'h8000, 16'h1111, 1'b1, 1'b0));
      send_request(make_req(16'h8000, '0, 1'b0, 1'b1));
      set_draw_count(rsmp_pkg::CNT_W'(1));
      send_request(make_req(16'h8000, W_MAX, 1'b1, 1'b0));
      send_request(make_req(16'h8000, '0, 1'b0, 1'b1));
   endtask

   // Draw counts above 1024 are used as they are.
   task automatic test_count_beyond_range;
      set_draw_count({rsmp_pkg::CNT_W{1'b1}});
      send_request(make_req(16'h4000, 16'h1234, 1'b1, 1'b0));
      send_request(make_req(16'h4000, '0, 1'b0, 1'b0));
      send_request(make_req(16'h8000, '0, 1'b0, 1'b1));
      set_draw_count(rsmp_pkg::CNT_W'(1025));
      send_request(make_req(W_MAX, 16'h0F0F, 1'b1, 1'b1));
   endtask

   // Lower the draw count below the draws already served in a pass.
   task automatic test_count_lowered_mid_pass;
      set_draw_count(rsmp_pkg::COUNT_RESET);
      send_request(make_req(16'hC000, rsmp_pkg::WEIGHT_BITS'($urandom_range(0, 65535)),
                            1'b1, 1'b0));
      set_draw_count(rsmp_pkg::CNT_W'(16));
      send_request(make_req(16'h2000, '0, 1'b0, 1'b0));
      send_request(make_req(16'h2000, '0, 1'b0, 1'b1));
   endtask

   // Hold the receiver off for a long stretch while requests keep coming,
   // so the block fills and stalls its input.
   task automatic test_receiver_hold;
      set_draw_count(rsmp_pkg::CNT_W'(64));
      req_idle_on     = 1'b0;
      rsp_hold_cycles = 60;
      send_pass(16, 1'b1, 1'b1, 1'b0);
      req_idle_on     = 1'b1;
      wait_drained();
   endtask

   // One long pass of heavy weights: the running sum runs far past 1.0, so
   // draws stop at n and later particles get no copies.
   task automatic test_long_pass;
      set_draw_count(rsmp_pkg::COUNT_RESET);
      req_idle_on = 1'b0;
      send_request(make_req(W_MAX, 16'h8001, 1'b1, 1'b0));
      repeat (198) send_request(make_req(W_MAX, '0, 1'b0, 1'b0));
      send_request(make_req(W_MAX, '0, 1'b0, 1'b1));
      req_idle_on = 1'b1;
   endtask

   // Random passes in phases, each with its own draw count and idling mix.
   // Mostly well-formed; the rest lack a mark or are plain noise.
   task automatic test_random_passes;
      int sent, phase_left, kind, m;
      logic [rsmp_pkg::CNT_W-1:0] n;
      sent       = 0;
      phase_left = 0;
      while (sent < 700) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 9))
               0:       n = '0;
               1:       n = rsmp_pkg::CNT_W'(1);
               2:       n = rsmp_pkg::CNT_W'(2);
               3:       n = {rsmp_pkg::CNT_W{1'b1}};
               4:       n = rsmp_pkg::COUNT_RESET;
               5, 6:    n = rsmp_pkg::CNT_W'($urandom_range(1, 64));
               default: n = rsmp_pkg::CNT_W'($urandom_range(1, 1024));
            endcase
            set_draw_count(n);
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            phase_left  = $urandom_range(4, 12);
         end
         m    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
         kind = $urandom_range(0, 99);
         if (kind < 70)      send_pass(m, 1'b1, 1'b1, 1'b0);
         else if (kind < 80) send_pass(m, 1'b1, 1'b0, 1'b0);
         else if (kind < 88) send_pass(m, 1'b0, 1'b1, 1'b0);
         else                send_pass(m, 1'b0, 1'b0, 1'b1);
         sent += m;
         phase_left--;
      end
   endtask

   initial begin
      // Match the shadow state to the block's reset values.
      sum_acc    = '0;
      draw_next  = '0;
      slot_pos   = '0;
      offset_lat = '0;
      draw_total = rsmp_pkg::COUNT_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      test_before_first();
      test_field_extremes();
      test_draw_count_edges();
      test_count_beyond_range();
      test_count_lowered_mid_pass();
      test_receiver_hold();
      test_long_pass();
      test_random_passes();

      wait_drained();
      if (fail_count == 0 && await_tail == await_head) begin
         $display("PASS systematic_resampler");
      end else begin
         $display("FAIL systematic_resampler");
      end
      $finish;
   end

   // Bound the run well beyond the slowest correct one.
   initial begin
      #8000000;
      $display("FAIL systematic_resampler");
      $finish;
   end

endmodule
